### src/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg: HTTP request header parser shared definitions
// Transfer payloads, parse states, result codes and character classes.
// ----------------------------------------------------------------------------
package hrp_pkg;

  typedef enum logic [19:0] {
    ST_METHOD_START = 20'h00001,
    ST_METHOD       = 20'h00002,
    ST_URI          = 20'h00004,
    ST_VER_H        = 20'h00008,
    ST_VER_T1       = 20'h00010,
    ST_VER_T2       = 20'h00020,
    ST_VER_P        = 20'h00040,
    ST_VER_SLASH    = 20'h00080,
    ST_MAJOR_START  = 20'h00100,
    ST_MAJOR        = 20'h00200,
    ST_MINOR_START  = 20'h00400,
    ST_MINOR        = 20'h00800,
    ST_LF_1         = 20'h01000,
    ST_LINE_START   = 20'h02000,
    ST_LWS          = 20'h04000,
    ST_NAME         = 20'h08000,
    ST_COLON_SPACE  = 20'h10000,
    ST_VALUE        = 20'h20000,
    ST_LF_2         = 20'h40000,
    ST_LF_3         = 20'h80000
  } state_t;

  typedef enum logic [1:0] {
    RES_MORE  = 2'd0,
    RES_DONE  = 2'd1,
    RES_ERROR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_METHOD = 3'd1,
    CLS_URI    = 3'd2,
    CLS_NAME   = 3'd3,
    CLS_VALUE  = 3'd4
  } cls_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CTL_MAX = 8'd31;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  byte_class;
    logic        header_begins;
    logic [7:0]  echoed_byte;
    logic [15:0] version_major;
    logic [15:0] version_minor;
  } out_t;

  typedef struct packed {
    status_t status;
    cls_t    byte_class;
    logic    header_begins;
  } resp_t;

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CH_CTL_MAX) || (c == CH_DEL);
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    logic sep;
    unique case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
      8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
      8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
      default:                    sep = 1'b0;
    endcase
    return sep;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_separator(c);
  endfunction

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

endpackage

### src/hrp_stream_if.sv
// ----------------------------------------------------------------------------
// hrp_stream_if: valid/ready stream channel
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface hrp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/hrp_step.sv
// ----------------------------------------------------------------------------
// hrp_step: single-byte parse step
// Next parse state, version accumulators and per-byte response.
// ----------------------------------------------------------------------------
module hrp_step #(
  parameter int VERSION_BITS = 16
) (
  input  hrp_pkg::state_t          st_cur,
  input  logic                     seen_cur,
  input  logic [VERSION_BITS-1:0]  major_cur,
  input  logic [VERSION_BITS-1:0]  minor_cur,
  input  logic [7:0]               c,
  output hrp_pkg::state_t          st_nxt,
  output logic                     seen_nxt,
  output logic [VERSION_BITS-1:0]  major_nxt,
  output logic [VERSION_BITS-1:0]  minor_nxt,
  output hrp_pkg::resp_t           resp
);

  localparam int AW = VERSION_BITS + 4;

  logic                    use_major;
  logic [VERSION_BITS-1:0] acc_sel;
  logic [AW-1:0]           acc_ext;
  logic [AW-1:0]           prod;
  logic [VERSION_BITS-1:0] acc_sat;

  // shared decimal accumulator: acc * 10 + digit, saturating
  assign use_major = (st_cur == hrp_pkg::ST_MAJOR_START) || (st_cur == hrp_pkg::ST_MAJOR);
  assign acc_sel   = use_major ? major_cur : minor_cur;
  assign acc_ext   = {4'b0, acc_sel};
  assign prod      = (acc_ext << 3) + (acc_ext << 1) + AW'(c[3:0]);
  assign acc_sat   = (|prod[AW-1:VERSION_BITS]) ? {VERSION_BITS{1'b1}}
                                                : prod[VERSION_BITS-1:0];

  always_comb begin
    st_nxt             = st_cur;
    seen_nxt           = seen_cur;
    major_nxt          = major_cur;
    minor_nxt          = minor_cur;
    resp.status        = hrp_pkg::RES_MORE;
    resp.byte_class    = hrp_pkg::CLS_NONE;
    resp.header_begins = 1'b0;
    unique case (st_cur)
      hrp_pkg::ST_METHOD_START: begin
        if (!hrp_pkg::is_token(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          st_nxt          = hrp_pkg::ST_METHOD;
          resp.byte_class = hrp_pkg::CLS_METHOD;
        end
      end
      hrp_pkg::ST_METHOD: begin
        if (c == hrp_pkg::CH_SP) begin
          st_nxt = hrp_pkg::ST_URI;
        end else if (!hrp_pkg::is_token(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          resp.byte_class = hrp_pkg::CLS_METHOD;
        end
      end
      hrp_pkg::ST_URI: begin
        if (c == hrp_pkg::CH_SP) begin
          st_nxt = hrp_pkg::ST_VER_H;
        end else if (hrp_pkg::is_ctl(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          resp.byte_class = hrp_pkg::CLS_URI;
        end
      end
      hrp_pkg::ST_VER_H: begin
        if (c != hrp_pkg::CH_H) resp.status = hrp_pkg::RES_ERROR;
        else st_nxt = hrp_pkg::ST_VER_T1;
      end
      hrp_pkg::ST_VER_T1: begin
        if (c != hrp_pkg::CH_T) resp.status = hrp_pkg::RES_ERROR;
        else st_nxt = hrp_pkg::ST_VER_T2;
      end
      hrp_pkg::ST_VER_T2: begin
        if (c != hrp_pkg::CH_T) resp.status = hrp_pkg::RES_ERROR;
        else st_nxt = hrp_pkg::ST_VER_P;
      end
      hrp_pkg::ST_VER_P: begin
        if (c != hrp_pkg::CH_P) resp.status = hrp_pkg::RES_ERROR;
        else st_nxt = hrp_pkg::ST_VER_SLASH;
      end
      hrp_pkg::ST_VER_SLASH: begin
        if (c != hrp_pkg::CH_SLASH) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          major_nxt = '0;
          minor_nxt = '0;
          st_nxt    = hrp_pkg::ST_MAJOR_START;
        end
      end
      hrp_pkg::ST_MAJOR_START: begin
        if (!hrp_pkg::dec_digit(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          major_nxt = acc_sat;
          st_nxt    = hrp_pkg::ST_MAJOR;
        end
      end
      hrp_pkg::ST_MAJOR: begin
        if (c == hrp_pkg::CH_DOT) begin
          st_nxt = hrp_pkg::ST_MINOR_START;
        end else if (!hrp_pkg::dec_digit(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          major_nxt = acc_sat;
        end
      end
      hrp_pkg::ST_MINOR_START: begin
        if (!hrp_pkg::dec_digit(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          minor_nxt = acc_sat;
          st_nxt    = hrp_pkg::ST_MINOR;
        end
      end
      hrp_pkg::ST_MINOR: begin
        if (c == hrp_pkg::CH_CR) begin
          st_nxt = hrp_pkg::ST_LF_1;
        end else if (!hrp_pkg::dec_digit(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          minor_nxt = acc_sat;
        end
      end
      hrp_pkg::ST_LF_1: begin
        if (c != hrp_pkg::CH_LF) resp.status = hrp_pkg::RES_ERROR;
        else st_nxt = hrp_pkg::ST_LINE_START;
      end
      hrp_pkg::ST_LINE_START: begin
        if (c == hrp_pkg::CH_CR) begin
          st_nxt = hrp_pkg::ST_LF_3;
        end else if (seen_cur && (c == hrp_pkg::CH_SP || c == hrp_pkg::CH_HT)) begin
          st_nxt = hrp_pkg::ST_LWS;
        end else if (!hrp_pkg::is_token(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          seen_nxt           = 1'b1;
          st_nxt             = hrp_pkg::ST_NAME;
          resp.byte_class    = hrp_pkg::CLS_NAME;
          resp.header_begins = 1'b1;
        end
      end
      hrp_pkg::ST_LWS: begin
        if (c == hrp_pkg::CH_CR) begin
          st_nxt = hrp_pkg::ST_LF_2;
        end else if (c == hrp_pkg::CH_SP || c == hrp_pkg::CH_HT) begin
          st_nxt = hrp_pkg::ST_LWS;
        end else if (hrp_pkg::is_ctl(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          st_nxt          = hrp_pkg::ST_VALUE;
          resp.byte_class = hrp_pkg::CLS_VALUE;
        end
      end
      hrp_pkg::ST_NAME: begin
        if (c == hrp_pkg::CH_COLON) begin
          st_nxt = hrp_pkg::ST_COLON_SPACE;
        end else if (!hrp_pkg::is_token(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          resp.byte_class = hrp_pkg::CLS_NAME;
        end
      end
      hrp_pkg::ST_COLON_SPACE: begin
        if (c != hrp_pkg::CH_SP) resp.status = hrp_pkg::RES_ERROR;
        else st_nxt = hrp_pkg::ST_VALUE;
      end
      hrp_pkg::ST_VALUE: begin
        if (c == hrp_pkg::CH_CR) begin
          st_nxt = hrp_pkg::ST_LF_2;
        end else if (hrp_pkg::is_ctl(c)) begin
          resp.status = hrp_pkg::RES_ERROR;
        end else begin
          resp.byte_class = hrp_pkg::CLS_VALUE;
        end
      end
      hrp_pkg::ST_LF_2: begin
        if (c != hrp_pkg::CH_LF) resp.status = hrp_pkg::RES_ERROR;
        else st_nxt = hrp_pkg::ST_LINE_START;
      end
      hrp_pkg::ST_LF_3: begin
        resp.status = (c == hrp_pkg::CH_LF) ? hrp_pkg::RES_DONE : hrp_pkg::RES_ERROR;
      end
      default: begin
        resp.status = hrp_pkg::RES_ERROR;
      end
    endcase
  end

endmodule

### src/http_request_header_parser_core.sv
// The result is registered and becomes valid in the cycle after the input transfer.
// Throughput: 1 byte per cycle while the result register is empty or out_if is ready; the parse step is combinational.
// Result register holds a finished result while the next byte is taken.
// Reset (synchronous, rst_n low): parser at method start, version counts zero,
// no header seen, result register empty.
// ----------------------------------------------------------------------------
// http_request_header_parser_core: HTTP request-line and header parser
// Checks a request byte stream and tags each byte with status and class.
// ----------------------------------------------------------------------------
module http_request_header_parser_core #(
  parameter int VERSION_BITS = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  hrp_stream_if.sink                       in_if,
  hrp_stream_if.source                     out_if
);

  hrp_pkg::state_t         st_r;
  logic                    seen_r;
  logic [VERSION_BITS-1:0] major_r;
  logic [VERSION_BITS-1:0] minor_r;
  logic                    out_valid_r;
  hrp_pkg::out_t           out_r;

  hrp_pkg::in_t            in_pl;
  hrp_pkg::state_t         st_cur;
  logic                    seen_cur;
  logic [VERSION_BITS-1:0] major_cur;
  logic [VERSION_BITS-1:0] minor_cur;
  hrp_pkg::state_t         st_nxt;
  logic                    seen_nxt;
  logic [VERSION_BITS-1:0] major_nxt;
  logic [VERSION_BITS-1:0] minor_nxt;
  hrp_pkg::resp_t          resp;
  hrp_pkg::out_t           out_nxt;
  logic [VERSION_BITS+15:0] major_wide;
  logic [VERSION_BITS+15:0] minor_wide;
  logic                    in_xfer;

  assign in_pl        = in_if.payload;
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.payload = out_r;

  // restart: parse this byte from a cleared state
  assign st_cur    = in_pl.restart ? hrp_pkg::ST_METHOD_START : st_r;
  assign seen_cur  = in_pl.restart ? 1'b0 : seen_r;
  assign major_cur = in_pl.restart ? '0 : major_r;
  assign minor_cur = in_pl.restart ? '0 : minor_r;

  hrp_step #(
    .VERSION_BITS (VERSION_BITS)
  ) u_step (
    .st_cur    (st_cur),
    .seen_cur  (seen_cur),
    .major_cur (major_cur),
    .minor_cur (minor_cur),
    .c         (in_pl.data_byte),
    .st_nxt    (st_nxt),
    .seen_nxt  (seen_nxt),
    .major_nxt (major_nxt),
    .minor_nxt (minor_nxt),
    .resp      (resp)
  );

  assign major_wide = {16'b0, major_nxt};
  assign minor_wide = {16'b0, minor_nxt};

  always_comb begin
    out_nxt.status        = resp.status;
    out_nxt.byte_class    = resp.byte_class;
    out_nxt.header_begins = resp.header_begins;
    out_nxt.echoed_byte   = in_pl.data_byte;
    out_nxt.version_major = major_wide[15:0];
    out_nxt.version_minor = minor_wide[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= hrp_pkg::ST_METHOD_START;
      seen_r      <= 1'b0;
      major_r     <= '0;
      minor_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_r        <= st_nxt;
        seen_r      <= seen_nxt;
        major_r     <= major_nxt;
        minor_r     <= minor_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_r <= out_nxt;
    end
  end

endmodule

### tb/sv/http_request_header_parser_core_tb.sv
// ----------------------------------------------------------------------------
// http_request_header_parser_core_tb: self-checking bench for the parser core
// Drives HTTP request bytes over the valid/ready input channel, first a short
// table of hand-picked bytes, then random well-formed requests with random
// corruption and noise. Every result transfer is compared field by field with
// a parser model or typed-row tags; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module http_request_header_parser_core_tb;
  import hrp_pkg::*;

  localparam int VER_BITS      = 16;
  localparam int unsigned VER_TOP = (1 << VER_BITS) - 1;
  localparam int RANDOM_BYTES  = 350;
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_ROWS      = 32;

  typedef struct {
    logic [7:0] data;
    logic       restart;
    bit         typed;
    status_t    st;
    cls_t       cls;
    logic       begins;
  } row_t;

  logic clk;
  logic rst_n;

  hrp_stream_if #(.payload_t(in_t))  in_ch ();
  hrp_stream_if #(.payload_t(out_t)) out_ch ();

  http_request_header_parser_core #(.VERSION_BITS(VER_BITS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // parser model state
  state_t      model_state;
  logic [15:0] model_major;
  logic [15:0] model_minor;
  bit          model_seen_header;

  out_t pending_tags[$];
  in_t  byte_stream[$];

  bit steady;
  int fail_count;
  int bytes_sent;
  int results_checked;
  int done_seen;
  int error_seen;
  int requests_built;
  int stall_cycles;

  row_t directed_rows [NUM_ROWS] = '{
    '{8'h00,    1'b1, 1'b1, RES_ERROR, CLS_NONE,   1'b0},
    '{8'hFF,    1'b0, 1'b1, RES_ERROR, CLS_NONE,   1'b0},
    '{"G",      1'b0, 1'b1, RES_MORE,  CLS_METHOD, 1'b0},
    '{CH_SP,    1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{8'h80,    1'b0, 1'b1, RES_MORE,  CLS_URI,    1'b0},
    '{CH_SP,    1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_H,     1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_T,     1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_T,     1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_P,     1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_SLASH, 1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{"7",      1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{"0",      1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{"0",      1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{"0",      1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{"0",      1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_DOT,   1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{"1",      1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_CR,    1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_LF,    1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_SP,    1'b0, 1'b1, RES_ERROR, CLS_NONE,   1'b0},
    '{"X",      1'b0, 1'b1, RES_MORE,  CLS_NAME,   1'b1},
    '{CH_COLON, 1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_SP,    1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{8'hFF,    1'b0, 1'b1, RES_MORE,  CLS_VALUE,  1'b0},
    '{CH_HT,    1'b0, 1'b1, RES_ERROR, CLS_NONE,   1'b0},
    '{CH_CR,    1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_LF,    1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_CR,    1'b0, 1'b0, RES_MORE,  CLS_NONE,   1'b0},
    '{CH_LF,    1'b0, 1'b1, RES_DONE,  CLS_NONE,   1'b0},
    '{CH_LF,    1'b0, 1'b1, RES_DONE,  CLS_NONE,   1'b0},
    '{"A",      1'b0, 1'b1, RES_ERROR, CLS_NONE,   1'b0}
  };

  function automatic bit ctl_char(logic [7:0] c);
    return (c <= 8'd31) || (c == 8'd127);
  endfunction

  function automatic bit sep_char(logic [7:0] c);
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", CH_SP, CH_HT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit token_char(logic [7:0] c);
    return (c < 8'd128) && !ctl_char(c) && !sep_char(c);
  endfunction

  function automatic logic [15:0] decimal_push(logic [15:0] acc, logic [7:0] c);
    int unsigned v;
    v = int'(acc) * 10 + int'(c - CH_0);
    return (v > VER_TOP) ? VER_TOP[15:0] : v[15:0];
  endfunction

  // one parse step; an error leaves all state as it stood after any restart
  function automatic out_t parse_byte(in_t item);
    out_t       r;
    logic [7:0] c;
    c = item.data_byte;
    if (item.restart) begin
      model_state       = ST_METHOD_START;
      model_major       = '0;
      model_minor       = '0;
      model_seen_header = 1'b0;
    end
    r = '0;
    r.status      = RES_MORE;
    r.byte_class  = CLS_NONE;
    r.echoed_byte = c;
    case (model_state)
      ST_METHOD_START: begin
        if (token_char(c)) begin
          model_state  = ST_METHOD;
          r.byte_class = CLS_METHOD;
        end else r.status = RES_ERROR;
      end
      ST_METHOD: begin
        if (c == CH_SP) model_state = ST_URI;
        else if (token_char(c)) r.byte_class = CLS_METHOD;
        else r.status = RES_ERROR;
      end
      ST_URI: begin
        if (c == CH_SP) model_state = ST_VER_H;
        else if (ctl_char(c)) r.status = RES_ERROR;
        else r.byte_class = CLS_URI;
      end
      ST_VER_H: begin
        if (c == CH_H) model_state = ST_VER_T1;
        else r.status = RES_ERROR;
      end
      ST_VER_T1: begin
        if (c == CH_T) model_state = ST_VER_T2;
        else r.status = RES_ERROR;
      end
      ST_VER_T2: begin
        if (c == CH_T) model_state = ST_VER_P;
        else r.status = RES_ERROR;
      end
      ST_VER_P: begin
        if (c == CH_P) model_state = ST_VER_SLASH;
        else r.status = RES_ERROR;
      end
      ST_VER_SLASH: begin
        if (c == CH_SLASH) begin
          model_major = '0;
          model_minor = '0;
          model_state = ST_MAJOR_START;
        end else r.status = RES_ERROR;
      end
      ST_MAJOR_START: begin
        if (c >= CH_0 && c <= CH_9) begin
          model_major = decimal_push(model_major, c);
          model_state = ST_MAJOR;
        end else r.status = RES_ERROR;
      end
      ST_MAJOR: begin
        if (c == CH_DOT) model_state = ST_MINOR_START;
        else if (c >= CH_0 && c <= CH_9) model_major = decimal_push(model_major, c);
        else r.status = RES_ERROR;
      end
      ST_MINOR_START: begin
        if (c >= CH_0 && c <= CH_9) begin
          model_minor = decimal_push(model_minor, c);
          model_state = ST_MINOR;
        end else r.status = RES_ERROR;
      end
      ST_MINOR: begin
        if (c == CH_CR) model_state = ST_LF_1;
        else if (c >= CH_0 && c <= CH_9) model_minor = decimal_push(model_minor, c);
        else r.status = RES_ERROR;
      end
      ST_LF_1: begin
        if (c == CH_LF) model_state = ST_LINE_START;
        else r.status = RES_ERROR;
      end
      ST_LINE_START: begin
        if (c == CH_CR) model_state = ST_LF_3;
        else if (model_seen_header && (c == CH_SP || c == CH_HT)) model_state = ST_LWS;
        else if (token_char(c)) begin
          model_seen_header = 1'b1;
          model_state       = ST_NAME;
          r.byte_class      = CLS_NAME;
          r.header_begins   = 1'b1;
        end else r.status = RES_ERROR;
      end
      ST_LWS: begin
        if (c == CH_CR) model_state = ST_LF_2;
        else if (c == CH_SP || c == CH_HT) r.status = RES_MORE;
        else if (ctl_char(c)) r.status = RES_ERROR;
        else begin
          model_state  = ST_VALUE;
          r.byte_class = CLS_VALUE;
        end
      end
      ST_NAME: begin
        if (c == CH_COLON) model_state = ST_COLON_SPACE;
        else if (token_char(c)) r.byte_class = CLS_NAME;
        else r.status = RES_ERROR;
      end
      ST_COLON_SPACE: begin
        if (c == CH_SP) model_state = ST_VALUE;
        else r.status = RES_ERROR;
      end
      ST_VALUE: begin
        if (c == CH_CR) model_state = ST_LF_2;
        else if (ctl_char(c)) r.status = RES_ERROR;
        else r.byte_class = CLS_VALUE;
      end
      ST_LF_2: begin
        if (c == CH_LF) model_state = ST_LINE_START;
        else r.status = RES_ERROR;
      end
      ST_LF_3: begin
        r.status = (c == CH_LF) ? RES_DONE : RES_ERROR;
      end
      default: r.status = RES_ERROR;
    endcase
    r.version_major = model_major;
    r.version_minor = model_minor;
    return r;
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 37);
  endfunction

  // drive one byte; called and returns at a rising edge
  task automatic send_byte(input in_t item, input bit typed, input status_t t_st,
                           input cls_t t_cls, input logic t_beg);
    out_t want;
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = parse_byte(item);
    if (typed) begin
      want.status        = t_st;
      want.byte_class    = t_cls;
      want.header_begins = t_beg;
    end
    pending_tags.insert(pending_tags.size(), want);
    bytes_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic rs);
    in_t t;
    t.data_byte = b;
    t.restart   = rs;
    byte_stream.insert(byte_stream.size(), t);
  endtask

  function automatic logic [7:0] rand_token();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!token_char(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_text(input int lo);
    logic [7:0] c;
    do c = 8'($urandom_range(lo, 255)); while (ctl_char(c));
    return c;
  endfunction

  task automatic push_digits();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2);
    repeat (n) push_byte(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
  endtask

  task automatic build_request();
    int idx;
    push_byte(rand_token(), ($urandom_range(0, 3) != 0));
    repeat ($urandom_range(0, 4)) push_byte(rand_token(), 1'b0);
    push_byte(CH_SP, 1'b0);
    repeat ($urandom_range(1, 8)) push_byte(rand_text(33), 1'b0);
    push_byte(CH_SP, 1'b0);
    push_byte(CH_H, 1'b0);
    push_byte(CH_T, 1'b0);
    push_byte(CH_T, 1'b0);
    push_byte(CH_P, 1'b0);
    push_byte(CH_SLASH, 1'b0);
    push_digits();
    push_byte(CH_DOT, 1'b0);
    push_digits();
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 5)) push_byte(rand_token(), 1'b0);
      push_byte(CH_COLON, 1'b0);
      push_byte(CH_SP, 1'b0);
      repeat ($urandom_range(0, 6)) push_byte(rand_text(32), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        repeat ($urandom_range(1, 2)) push_byte($urandom_range(0, 1) ? CH_SP : CH_HT, 1'b0);
        repeat ($urandom_range(0, 4)) push_byte(rand_text(32), 1'b0);
      end
      push_byte(CH_CR, 1'b0);
      push_byte(CH_LF, 1'b0);
    end
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);
    if ($urandom_range(0, 3) == 0) push_byte(CH_LF, 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, byte_stream.size() - 1);
      byte_stream[idx].data_byte = 8'($urandom_range(0, 255));
    end
    requests_built++;
  endtask

  task automatic report_field(input string field, input longint unsigned want,
                              input longint unsigned got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    fail_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check each transfer, then pick ready for the next cycle
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    out_t want;
    out_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      results_checked++;
      if (got.status == RES_DONE) done_seen++;
      if (got.status == RES_ERROR) error_seen++;
      if (pending_tags.size() == 0) begin
        $display("%0t: unexpected result, actual %0h", $time, got);
        fail_count++;
      end else begin
        want = pending_tags.pop_front();
        if (got.status !== want.status)
          report_field("status", want.status, got.status);
        if (got.byte_class !== want.byte_class)
          report_field("byte_class", want.byte_class, got.byte_class);
        if (got.header_begins !== want.header_begins)
          report_field("header_begins", want.header_begins, got.header_begins);
        if (got.echoed_byte !== want.echoed_byte)
          report_field("echoed_byte", want.echoed_byte, got.echoed_byte);
        if (got.version_major !== want.version_major)
          report_field("version_major", want.version_major, got.version_major);
        if (got.version_minor !== want.version_minor)
          report_field("version_minor", want.version_minor, got.version_minor);
      end
    end
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 37);
  end

  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int   random_sent;
    in_t  item;
    fail_count        = 0;
    bytes_sent        = 0;
    results_checked   = 0;
    done_seen         = 0;
    error_seen        = 0;
    requests_built    = 0;
    steady            = 1'b0;
    model_state       = ST_METHOD_START;
    model_major       = '0;
    model_minor       = '0;
    model_seen_header = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      item.data_byte = directed_rows[i].data;
      item.restart   = directed_rows[i].restart;
      send_byte(item, directed_rows[i].typed, directed_rows[i].st,
                directed_rows[i].cls, directed_rows[i].begins);
    end

    // hold off until the table has fully drained
    in_ch.valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);

    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 8))
          push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
      end else begin
        build_request();
      end
      while (byte_stream.size() != 0) begin
        steady = (random_sent >= 150) && (random_sent < 260);
        send_byte(byte_stream.pop_front(), 1'b0, RES_MORE, CLS_NONE, 1'b0);
        random_sent++;
      end
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_tags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes: %0d table rows, %0d random requests plus noise bursts",
             bytes_sent, NUM_ROWS, requests_built);
    $display("Checked %0d results, %0d complete and %0d syntax errors among them",
             results_checked, done_seen, error_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
